// ===== hw/rtl/rgbds_pkg.sv =====
// ---------------------------------------------------------------------------
// rgbds_pkg: shared types, constants and helpers of the RGB565 downscaler
// Field layout of RGB565 pixels and of packed pair sums, register codes and
// the control group passed from the position counters to the datapath.
// ---------------------------------------------------------------------------
package rgbds_pkg;

	localparam int PIX_W        = 16;
	localparam int PAIR_W       = 19;
	localparam int CFG_W        = 11;
	localparam int ROW_W        = 10;
	localparam int HEIGHT_LIMIT = 1024;

	localparam int RED_SHIFT   = 11;
	localparam int GREEN_SHIFT = 5;
	localparam logic [5:0] GREEN_MASK = 6'h3f;
	localparam logic [4:0] FIVE_MASK  = 5'h1f;

	// Register map of the configuration port
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Where the current pixel sits within its 2x2 block and frame
	typedef struct packed {
		logic odd_col;
		logic odd_row;
		logic last;
	} pos_ctl_t;

	// Per-channel sums of two pixels, packed red 18:13, green 12:6, blue 5:0
	function automatic logic [PAIR_W-1:0] pair_sum(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b
	);
		logic [5:0] r;
		logic [6:0] g;
		logic [5:0] bl;
		r  = {1'b0, a[PIX_W-1:RED_SHIFT]} + {1'b0, b[PIX_W-1:RED_SHIFT]};
		g  = {1'b0, a[RED_SHIFT-1:GREEN_SHIFT] & GREEN_MASK}
			+ {1'b0, b[RED_SHIFT-1:GREEN_SHIFT] & GREEN_MASK};
		bl = {1'b0, a[GREEN_SHIFT-1:0] & FIVE_MASK} + {1'b0, b[GREEN_SHIFT-1:0] & FIVE_MASK};
		return {r, g, bl};
	endfunction

	// Rounded average of two pair sums, packed as RGB565
	function automatic logic [PIX_W-1:0] block_average(
		input logic [PAIR_W-1:0] above,
		input logic [PAIR_W-1:0] cur
	);
		logic [6:0] r;
		logic [7:0] g;
		logic [6:0] bl;
		r  = 7'({1'b0, above[18:13]}) + 7'({1'b0, cur[18:13]}) + 7'd2;
		g  = 8'({1'b0, above[12:6]}) + 8'({1'b0, cur[12:6]}) + 8'd2;
		bl = 7'({1'b0, above[5:0]}) + 7'({1'b0, cur[5:0]}) + 7'd2;
		return {r[6:2] & FIVE_MASK, g[7:2] & GREEN_MASK, bl[6:2] & FIVE_MASK};
	endfunction

endpackage

// ===== hw/rtl/rgbds_if.sv =====
// ---------------------------------------------------------------------------
// rgbds_if: stream channels of the RGB565 downscaler
// Input pixel channel and output pixel channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rgbds_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;
	logic        start_of_frame;

	modport source (output valid, output pixel, output start_of_frame, input ready);
	modport sink (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface rgbds_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] scaled_pixel;
	logic        last_of_frame;

	modport source (output valid, output scaled_pixel, output last_of_frame, input ready);
	modport sink (input valid, input scaled_pixel, input last_of_frame, output ready);
endinterface

// ===== hw/rtl/rgbds_position.sv =====
// ---------------------------------------------------------------------------
// rgbds_position: column and row counters
// Track the position of the next pixel, clamp the frame size and flag the
// pixel that closes the last 2x2 block of a frame.
// ---------------------------------------------------------------------------
module rgbds_position
	import rgbds_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	localparam int LINE_DEPTH = MAX_WIDTH / 2,
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      start_of_frame,
	input  logic [CFG_W-1:0]          frame_width,
	input  logic [CFG_W-1:0]          frame_height,
	output logic [IDX_W-1:0]          idx,
	output pos_ctl_t                  ctl
);

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int MW_W       = $clog2(MAX_WIDTH + 1);
	localparam int SZ_W       = ((MW_W > CFG_W) ? MW_W : CFG_W) + 1;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] x;
	logic [ROW_W-1:0] y;
	logic [SZ_W-1:0]  w_eff;
	logic [SZ_W-1:0]  w_ext;
	logic [SZ_W-1:0]  x_next;
	logic [CFG_W-1:0] h_eff;
	logic [CFG_W-1:0] y_next;
	logic             col_end;
	logic             row_end;

	// Clamp the frame size: zero acts as one, oversize acts as the limit
	always_comb begin
		w_ext = SZ_W'(frame_width);
		if (frame_width == '0) begin
			w_eff = SZ_W'(1);
		end else if (w_ext > SZ_W'(MAX_WIDTH)) begin
			w_eff = SZ_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (frame_height == '0) begin
			h_eff = CFG_W'(1);
		end else if (frame_height > CFG_W'(HEIGHT_LIMIT)) begin
			h_eff = CFG_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = frame_height;
		end
	end

	assign x       = start_of_frame ? '0 : col_q;
	assign y       = start_of_frame ? '0 : row_q;
	assign x_next  = SZ_W'(x) + SZ_W'(1);
	assign y_next  = CFG_W'(y) + CFG_W'(1);
	assign col_end = x_next >= w_eff;
	assign row_end = y_next >= h_eff;

	assign idx         = IDX_W'(x >> 1);
	assign ctl.odd_col = x[0];
	assign ctl.odd_row = y[0];
	assign ctl.last    = (x_next == (w_eff & ~SZ_W'(1))) && (y_next == (h_eff & ~CFG_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : y_next[ROW_W-1:0];
			end else begin
				col_q <= x_next[COL_W-1:0];
				row_q <= y;
			end
		end
	end

endmodule

// ===== hw/rtl/rgbds_line_store.sv =====
// ---------------------------------------------------------------------------
// rgbds_line_store: pair sum line memory
// One entry per pixel pair of a line; single port, registered read data.
// ---------------------------------------------------------------------------
module rgbds_line_store
	import rgbds_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	localparam int LINE_DEPTH = MAX_WIDTH / 2,
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic                 re,
	input  logic [IDX_W-1:0]     addr,
	input  logic [PAIR_W-1:0]    wdata,
	output logic [PAIR_W-1:0]    rdata
);

	logic [PAIR_W-1:0] mem [LINE_DEPTH];
	logic [PAIR_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[addr];
		end
	end

	assign rdata = rdata_s1;

endmodule

// ===== hw/rtl/rgbds_average.sv =====
// ---------------------------------------------------------------------------
// rgbds_average: block average and output register
// Combine the stored and current pair sums, round, and hold the result beat
// until the sink takes it.
// ---------------------------------------------------------------------------
module rgbds_average
	import rgbds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [PAIR_W-1:0] above_s1,
	input  logic [PAIR_W-1:0] cur_s1,
	input  logic              last_s1,
	output logic              advance,
	rgbds_out_if.source       pix_out
);

	logic              valid_q;
	logic [PIX_W-1:0]  scaled_q;
	logic              last_q;

	assign advance = !valid_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			scaled_q <= block_average(above_s1, cur_s1);
			last_q   <= last_s1;
		end
	end

	assign pix_out.valid         = valid_q;
	assign pix_out.scaled_pixel  = scaled_q;
	assign pix_out.last_of_frame = last_q;

endmodule

// ===== hw/rtl/rgb565_two_by_two_downscale.sv =====
// ---------------------------------------------------------------------------
// rgb565_two_by_two_downscale: RGB565 2x2 box filter downscaler
// Raster-order RGB565 in, one rounded 2x2 average out per closed block.
// ---------------------------------------------------------------------------
// Takes one pixel beat per clock while the output is not stalled; the
// result of each 2x2 block, closed by its bottom-right pixel, goes out
// through the line store read register and the output register. Pixels
// that do not close a block give no beat; an odd last column or row is
// dropped. The line store is a single-port memory of MAX_WIDTH/2 pair sums;
// even rows write it and odd rows read it, so the one port carries the full
// pixel rate. It has no reset and no clearing pass: it is ready straight out
// of reset. Frame size registers take effect at once; a size of zero acts
// as one and a size above the limit acts as the limit (MAX_WIDTH columns,
// 1024 rows). start_of_frame restarts the position at the top-left corner;
// after the last pixel of a frame the position wraps by itself.
// last_of_frame marks the bottom-right output pixel of the frame.
// ---------------------------------------------------------------------------
module rgb565_two_by_two_downscale
	import rgbds_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	rgbds_in_if.sink           pix_in,
	rgbds_out_if.source        pix_out
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [CFG_W-1:0]  frame_width_q;
	logic [CFG_W-1:0]  frame_height_q;
	logic [PIX_W-1:0]  held_left_q;
	logic [PAIR_W-1:0] cur_s1;
	logic [PAIR_W-1:0] above_s1;
	logic [PAIR_W-1:0] cur_pair;
	logic              valid_s1;
	logic              last_s1;
	logic              accept;
	logic              advance;
	logic              line_we;
	logic              line_re;
	logic [IDX_W-1:0]  idx;
	pos_ctl_t          ctl;

	// Configuration registers: write straight through, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(240);
			frame_height_q <= CFG_W'(240);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a new beat whenever stage 1 is empty or moves on this clock
	assign pix_in.ready = !valid_s1 || advance;
	assign accept       = pix_in.valid && pix_in.ready;

	rgbds_position #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_position (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.start_of_frame (pix_in.start_of_frame),
		.frame_width    (frame_width_q),
		.frame_height   (frame_height_q),
		.idx            (idx),
		.ctl            (ctl)
	);

	// Even column: hold the left pixel of the pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q <= '0;
		end else if (accept && !ctl.odd_col) begin
			held_left_q <= pix_in.pixel;
		end
	end

	assign cur_pair = pair_sum(held_left_q, pix_in.pixel);

	// Odd column: even rows store the pair sum, odd rows fetch the one above
	assign line_we = accept && ctl.odd_col && !ctl.odd_row;
	assign line_re = accept && ctl.odd_col && ctl.odd_row;

	rgbds_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (line_we),
		.re    (line_re),
		.addr  (idx),
		.wdata (cur_pair),
		.rdata (above_s1)
	);

	// Stage 1: current pair sum waits alongside the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= line_re;
		end
	end

	always_ff @(posedge clk) begin
		if (line_re) begin
			cur_s1  <= cur_pair;
			last_s1 <= ctl.last;
		end
	end

	rgbds_average u_average (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.above_s1 (above_s1),
		.cur_s1   (cur_s1),
		.last_s1  (last_s1),
		.advance  (advance),
		.pix_out  (pix_out)
	);

	// The single line store port is never asked to write and read at once
	a_line_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(line_we && line_re))
		else $error("line store write and read in the same cycle");

	// A beat that closes a block must show up in stage 1
	a_block_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		line_re |=> valid_s1)
		else $error("closing pixel did not reach stage 1");

	// A stalled stage 1 must hold its pair sum
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(cur_s1) && $stable(last_s1)))
		else $error("stage 1 changed while stalled");

	// No new beat may be taken while stage 1 is stalled
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !accept)
		else $error("beat accepted over a stalled stage 1");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the RGB565 2x2 downscaler
// Drives pixel beats in raster order under random back-pressure, works out
// every scaled beat in a predictor of its own and checks each output beat
// in order against it, across many frame sizes and size changes.
// ---------------------------------------------------------------------------
module tb_top
	import rgbds_pkg::*;
();

	localparam int MAX_W         = 1024;
	localparam int LINE_PAIRS    = MAX_W / 2;
	localparam int SETTLE_CYCLES = 8;    // extra wait after the last owed beat, for the pipe to empty
	localparam int STALL_LIMIT   = 1000; // cycles with no beat on either side
	localparam int IDLE_PERCENT  = 11;

	// Pixels picked for the directed 4x4 frame: black, white, pure primaries,
	// magenta and near-grey values whose block sums sit on rounding edges
	localparam logic [15:0] EDGE_PIXELS [0:15] = '{
		16'h0000, 16'hffff, 16'hf800, 16'h07e0,
		16'hffff, 16'hffff, 16'h001f, 16'hf81f,
		16'h0841, 16'h0842, 16'hfffe, 16'h0001,
		16'h0842, 16'h0841, 16'h0001, 16'h0000
	};

	typedef struct packed {
		logic [15:0] scaled_pixel;
		logic        last_of_frame;
	} scaled_beat_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	rgbds_in_if  pix_in_ch ();
	rgbds_out_if pix_out_ch ();

	rgb565_two_by_two_downscale #(
		.MAX_WIDTH (MAX_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch)
	);

	// Predictor state: the frame size registers as written, the line of
	// even-row pair sums, the left pixel of the open pair and the position
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [18:0]      pair_row [LINE_PAIRS];
	logic [15:0]      held_pixel;
	int               col_pos;
	int               row_pos;

	scaled_beat_t pending_scaled [$]; // scaled beats still owed by the block
	int           mismatches = 0;
	int           stall_cycles = 0;
	bit           no_idle = 1'b0;     // set for a stretch with no gaps at all

	always #5 clk = ~clk;

	// Size register as the block uses it: zero acts as one, clip at the limit
	function automatic int fit_size(input logic [CFG_W-1:0] v, input int limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return int'(v);
	endfunction

	// Channel-wise sum of two RGB565 pixels, red 18:13, green 12:6, blue 5:0
	function automatic logic [18:0] add_pair(input logic [15:0] a, input logic [15:0] b);
		logic [5:0] r;
		logic [6:0] g;
		logic [5:0] bl;
		r  = a[15:11] + b[15:11];
		g  = a[10:5] + b[10:5];
		bl = a[4:0] + b[4:0];
		return {r, g, bl};
	endfunction

	// Place one accepted pixel; queue a scaled beat when it closes a block
	function automatic void predict_beat(input logic [15:0] pix, input logic sof);
		int           w;
		int           h;
		int           x;
		int           y;
		int           idx;
		int           r;
		int           g;
		int           b;
		logic [18:0]  here;
		logic [18:0]  above;
		scaled_beat_t beat;
		w = fit_size(width_reg, MAX_W);
		h = fit_size(height_reg, HEIGHT_LIMIT);
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		x   = col_pos;
		y   = row_pos;
		idx = x >> 1;
		if (x % 2 == 0) begin
			held_pixel = pix;
		end else if (idx < LINE_PAIRS) begin
			here = add_pair(held_pixel, pix);
			if (y % 2 == 0) begin
				pair_row[idx] = here;
			end else begin
				// Bottom-right pixel: add the pair above, round and halve twice
				above = pair_row[idx];
				r = above[18:13] + here[18:13] + 2;
				g = above[12:6] + here[12:6] + 2;
				b = above[5:0] + here[5:0] + 2;
				beat.scaled_pixel  = {5'(r >> 2), 6'(g >> 2), 5'(b >> 2)};
				beat.last_of_frame = (x + 1 == (w & ~1)) && (y + 1 == (h & ~1));
				pending_scaled.push_back(beat);
			end
		end
		// Wrap at the end of a row, and at the end of the frame to the top
		if (x + 1 >= w) begin
			col_pos = 0;
			row_pos = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
		end
	endfunction

	// Random back-pressure on the output side
	always @(negedge clk) begin
		pix_out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Monitor: predict on each input beat first, then check each output beat,
	// so a same-edge pair is always handled in that order
	always @(posedge clk) begin
		scaled_beat_t want;
		bit           moved;
		moved = 1'b0;
		if (arst_n && pix_in_ch.valid && pix_in_ch.ready) begin
			predict_beat(pix_in_ch.pixel, pix_in_ch.start_of_frame);
			moved = 1'b1;
		end
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			moved = 1'b1;
			if (pending_scaled.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual pixel %h last %b",
					$time, pix_out_ch.scaled_pixel, pix_out_ch.last_of_frame);
				mismatches++;
			end else begin
				want = pending_scaled.pop_front();
				if (pix_out_ch.scaled_pixel !== want.scaled_pixel) begin
					$display("%0t: scaled_pixel expected %h actual %h",
						$time, want.scaled_pixel, pix_out_ch.scaled_pixel);
					mismatches++;
				end
				if (pix_out_ch.last_of_frame !== want.last_of_frame) begin
					$display("%0t: last_of_frame expected %b actual %b",
						$time, want.last_of_frame, pix_out_ch.last_of_frame);
					mismatches++;
				end
			end
		end
		// Watchdog: give up when nothing has moved for too long
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("tb_top: errors");
			$finish;
		end
	end

	// Offer one pixel beat and hold it until taken; enter and leave at a
	// falling edge, leaving valid high so back-to-back beats keep it high
	task automatic send_pixel(input logic [15:0] pix, input logic sof);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			pix_in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in_ch.valid          <= 1'b1;
		pix_in_ch.pixel          <= pix;
		pix_in_ch.start_of_frame <= sof;
		@(posedge clk);
		while (!pix_in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random pixels, the first one flagged as start of frame
	task automatic send_frame(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(16'($urandom), i == 0);
	endtask

	// Drop valid and wait until every owed beat is out and the pipe is empty
	task automatic settle();
		pix_in_ch.valid <= 1'b0;
		while (pending_scaled.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		if (which == REG_FRAME_WIDTH)
			width_reg = CFG_W'(value);
		else
			height_reg = CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// Reset size: one full row at the reset width and the first two pairs of
	// the next row, with no gaps on either side
	task automatic test_reset_size();
		no_idle = 1'b1;
		send_frame(244);
		settle();
		no_idle = 1'b0;
	endtask

	// Field extremes and rounding edges in a 4x4 frame, then a frame cut
	// short by a fresh start of frame
	task automatic test_edge_pixels();
		set_size(4, 4);
		for (int i = 0; i < 16; i++)
			send_pixel(EDGE_PIXELS[i], i == 0);
		send_frame(6);
		send_pixel(16'hffff, 1'b1);
		send_pixel(16'h0000, 1'b0);
		settle();
	endtask

	// Odd and degenerate sizes: drop the odd last column and row, treat zero
	// as one, and wrap at the end of a frame with no start of frame
	task automatic test_odd_sizes();
		int sizes [5][2] = '{'{5, 5}, '{3, 1}, '{1, 3}, '{0, 0}, '{7, 3}};
		int n;
		for (int k = 0; k < 5; k++) begin
			set_size(sizes[k][0], sizes[k][1]);
			n = fit_size(CFG_W'(sizes[k][0]), MAX_W)
				* fit_size(CFG_W'(sizes[k][1]), HEIGHT_LIMIT);
			send_frame(n);
			for (int i = 0; i < n; i++)
				send_pixel(16'($urandom), 1'b0);
			settle();
		end
	endtask

	// Shrink width and then height mid-frame; every line entry read later
	// was written by an earlier even row of the same frame
	task automatic test_size_change_mid_frame();
		set_size(8, 4);
		send_frame(11);          // row 0 whole, row 1 up to column 2
		settle();
		write_reg(REG_FRAME_WIDTH, 2);
		send_pixel(16'($urandom), 1'b0);   // column 3 of row 1, then wrap
		for (int i = 0; i < 3; i++)         // row 2 and the left pixel of row 3
			send_pixel(16'($urandom), 1'b0);
		settle();
		write_reg(REG_FRAME_HEIGHT, 2);
		send_pixel(16'($urandom), 1'b0);   // closes row 3, wraps to the top
		for (int i = 0; i < 4; i++)         // a whole 2x2 frame with no start flag
			send_pixel(16'($urandom), 1'b0);
		settle();
	endtask

	// Random small sizes; mostly whole frames, some cut short, some noise
	// with stray start flags
	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int n;
		int kind;
		sent = 0;
		while (sent < 200) begin
			if ($urandom_range(0, 99) < 85) begin
				w = $urandom_range(0, 12);
				h = $urandom_range(0, 8);
			end else begin
				w = $urandom_range(13, 32);
				h = $urandom_range(1, 6);
			end
			set_size(w, h);
			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 99);
				n = fit_size(CFG_W'(w), MAX_W) * fit_size(CFG_W'(h), HEIGHT_LIMIT);
				if (kind < 80) begin
					send_frame(n);
				end else if (kind < 92) begin
					n = $urandom_range(1, n);
					send_frame(n);
				end else begin
					n = $urandom_range(1, 20);
					for (int i = 0; i < n; i++)
						send_pixel(16'($urandom), i == 0 || $urandom_range(0, 7) == 0);
				end
				sent += n;
			end
			settle();
		end
	endtask

	initial begin
		// Drive every input to a known value before the first edge
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = REG_FRAME_WIDTH;
		cfg_data                 = '0;
		pix_in_ch.valid          = 1'b0;
		pix_in_ch.pixel          = '0;
		pix_in_ch.start_of_frame = 1'b0;
		pix_out_ch.ready         = 1'b0;
		width_reg                = 240;
		height_reg               = 240;
		held_pixel               = '0;
		col_pos                  = 0;
		row_pos                  = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_size();
		test_edge_pixels();
		test_odd_sizes();
		test_size_change_mid_frame();
		test_random_frames();

		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
